// ----- hdl/ptc_pkg.sv -----
// Package: widths, register indexes, step codes and control structs of the pivot turn controller
package ptc_pkg;

  localparam int PTC_HEADING_TOL_DEF = 256;
  localparam int PTC_FRAC_BITS_DEF   = 8;

  localparam int PTC_CFG_IDX_W  = 3;
  localparam int PTC_CFG_DATA_W = 24;

  localparam logic [PTC_CFG_IDX_W-1:0] REG_TARGET_DELTA  = 3'd0;
  localparam logic [PTC_CFG_IDX_W-1:0] REG_KP_HEADING    = 3'd1;
  localparam logic [PTC_CFG_IDX_W-1:0] REG_K_RATE_FF     = 3'd2;
  localparam logic [PTC_CFG_IDX_W-1:0] REG_KI_RATE       = 3'd3;
  localparam logic [PTC_CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd4;
  localparam logic [PTC_CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd5;
  localparam logic [PTC_CFG_IDX_W-1:0] REG_DWELL_TICKS   = 3'd6;
  localparam logic [PTC_CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 3'd7;

  localparam int PTC_OP_W = 3;
  localparam logic [PTC_OP_W-1:0] OP_IDLE  = 3'd0;
  localparam logic [PTC_OP_W-1:0] OP_ERR   = 3'd1;
  localparam logic [PTC_OP_W-1:0] OP_MULP  = 3'd2;
  localparam logic [PTC_OP_W-1:0] OP_RDES  = 3'd3;
  localparam logic [PTC_OP_W-1:0] OP_MULI  = 3'd4;
  localparam logic [PTC_OP_W-1:0] OP_INTEG = 3'd5;
  localparam logic [PTC_OP_W-1:0] OP_SUM   = 3'd6;
  localparam logic [PTC_OP_W-1:0] OP_SPEED = 3'd7;

  typedef struct packed {
    logic                capture;
    logic [PTC_OP_W-1:0] op;
    logic                load_out;
  } ptc_cmd_t;

  typedef struct packed {
    logic out_free;
  } ptc_sts_t;

endpackage

// ----- hdl/ptc_ifs.sv -----
// Channel interfaces: control tick input, wheel speed result, configuration write
interface ptc_in_if import ptc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               start_req;
  logic signed [17:0] heading;
  logic signed [15:0] yaw_rate;
  logic               rate_valid;
  logic [14:0]        rate_limit;
  modport source (output valid, start_req, heading, yaw_rate, rate_valid, rate_limit,
                  input ready);
  modport sink   (input valid, start_req, heading, yaw_rate, rate_valid, rate_limit,
                  output ready);
endinterface

interface ptc_out_if import ptc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [10:0] left_speed;
  logic signed [10:0] right_speed;
  logic               done_res;
  modport source (output valid, left_speed, right_speed, done_res, input ready);
  modport sink   (input valid, left_speed, right_speed, done_res, output ready);
endinterface

interface ptc_cfg_if import ptc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PTC_CFG_IDX_W-1:0]  index;
  logic [PTC_CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/ptc_ctrl.sv -----
// Step sequencer of the pivot turn controller
module ptc_ctrl import ptc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ptc_sts_t sts,
  output ptc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ERR   = 3'd1;
  localparam logic [2:0] S_MULP  = 3'd2;
  localparam logic [2:0] S_RDES  = 3'd3;
  localparam logic [2:0] S_MULI  = 3'd4;
  localparam logic [2:0] S_INTEG = 3'd5;
  localparam logic [2:0] S_SUM   = 3'd6;
  localparam logic [2:0] S_SPEED = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.op       = OP_IDLE;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_ERR;
      end
      S_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = S_MULP;
      end
      S_MULP: begin
        cmd.op    = OP_MULP;
        state_nxt = S_RDES;
      end
      S_RDES: begin
        cmd.op    = OP_RDES;
        state_nxt = S_MULI;
      end
      S_MULI: begin
        cmd.op    = OP_MULI;
        state_nxt = S_INTEG;
      end
      S_INTEG: begin
        cmd.op    = OP_INTEG;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_SPEED;
      end
      S_SPEED: begin
        // hold here until the output register can take the beat
        cmd.op       = OP_SPEED;
        cmd.load_out = sts.out_free;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/ptc_datapath.sv -----
// Datapath: configuration, loop state, shared multiplier, rounding, clamps, output register
module ptc_datapath import ptc_pkg::*; #(
  parameter int HEADING_TOLERANCE = PTC_HEADING_TOL_DEF,
  parameter int FRAC_BITS         = PTC_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ptc_cmd_t                  cmd,
  output ptc_sts_t                  sts,
  input  logic                      cfg_we,
  input  logic [PTC_CFG_IDX_W-1:0]  cfg_index,
  input  logic [PTC_CFG_DATA_W-1:0] cfg_data,
  input  logic                      in_start_req,
  input  logic signed [17:0]        in_heading,
  input  logic signed [15:0]        in_yaw_rate,
  input  logic                      in_rate_valid,
  input  logic [14:0]               in_rate_limit,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [10:0]        out_left_speed,
  output logic signed [10:0]        out_right_speed,
  output logic                      out_done_res
);

  localparam int ERR_W   = 20;
  localparam int MA_W    = 17;
  localparam int PROD_W  = MA_W + ERR_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int INTEG_W = 12 + FRAC_BITS;

  localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0]  HALF_S = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [ERR_W-1:0]  TOL    = ERR_W'(HEADING_TOLERANCE);

  // configuration
  logic signed [17:0] target_delta_r;
  logic [15:0]        kp_heading_r, k_rate_ff_r, ki_rate_r, dwell_ticks_r;
  logic [9:0]         integ_limit_r, speed_limit_r;
  logic [23:0]        timeout_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_delta_r  <= '0;
      kp_heading_r    <= 16'd256;
      k_rate_ff_r     <= 16'd256;
      ki_rate_r       <= '0;
      integ_limit_r   <= '0;
      speed_limit_r   <= 10'd1023;
      dwell_ticks_r   <= '0;
      timeout_ticks_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_DELTA:  target_delta_r  <= cfg_data[17:0];
        REG_KP_HEADING:    kp_heading_r    <= cfg_data[15:0];
        REG_K_RATE_FF:     k_rate_ff_r     <= cfg_data[15:0];
        REG_KI_RATE:       ki_rate_r       <= cfg_data[15:0];
        REG_INTEG_LIMIT:   integ_limit_r   <= cfg_data[9:0];
        REG_SPEED_LIMIT:   speed_limit_r   <= cfg_data[9:0];
        REG_DWELL_TICKS:   dwell_ticks_r   <= cfg_data[15:0];
        REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // captured tick
  logic signed [17:0] heading_r;
  logic signed [15:0] yaw_rate_r;
  logic               rate_valid_r;
  logic [14:0]        rate_limit_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      heading_r    <= in_heading;
      yaw_rate_r   <= in_yaw_rate;
      rate_valid_r <= in_rate_valid;
      rate_limit_r <= in_rate_limit;
    end
  end

  // working registers
  logic signed [ERR_W-1:0]   err_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [15:0]        rdes_r;
  logic signed [SUM_W-1:0]   sum_r;

  // loop state
  logic signed [17:0]        start_heading_r;
  logic signed [INTEG_W-1:0] integral_r;
  logic signed [15:0]        last_good_r;
  logic                      in_band_r;
  logic [15:0]               dwell_r;
  logic [23:0]               tick_r;

  // heading error
  logic signed [ERR_W-1:0] err_nxt;
  assign err_nxt = ERR_W'(target_delta_r) - (ERR_W'(heading_r) - ERR_W'(start_heading_r));

  // shared multiplier
  logic signed [MA_W-1:0]   mul_a;
  logic signed [ERR_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [16:0]       rate_diff;

  assign rate_diff = 17'(rdes_r) - 17'(last_good_r);

  always_comb begin
    unique case (cmd.op)
      OP_MULP: begin
        mul_a = {1'b0, kp_heading_r};
        mul_b = err_r;
      end
      OP_MULI: begin
        mul_a = {1'b0, ki_rate_r};
        mul_b = ERR_W'(rate_diff);
      end
      OP_INTEG: begin
        mul_a = {1'b0, k_rate_ff_r};
        mul_b = ERR_W'(rdes_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // rate demand: round half away, clamp to the tick's rate limit
  logic              prod_neg;
  logic [PROD_W-1:0] prod_mag, prod_rnd;
  logic [15:0]       rdes_mag;
  logic signed [15:0] rdes_nxt;

  assign prod_neg = prod_r[PROD_W-1];
  assign prod_mag = prod_neg ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign prod_rnd = (prod_mag + HALF_P) >> FRAC_BITS;
  assign rdes_mag = (prod_rnd > PROD_W'(rate_limit_r)) ? 16'(rate_limit_r) : prod_rnd[15:0];
  assign rdes_nxt = prod_neg ? -$signed(rdes_mag) : $signed(rdes_mag);

  // one adder serves the integral update and the speed sum
  logic signed [SUM_W-1:0]   add_w;
  logic signed [SUM_W-1:0]   ilim;
  logic signed [INTEG_W-1:0] integ_nxt;

  assign add_w = SUM_W'(prod_r) + SUM_W'(integral_r);
  assign ilim  = $signed(SUM_W'(integ_limit_r) << FRAC_BITS);

  always_comb begin
    if (add_w > ilim)       integ_nxt = INTEG_W'(ilim);
    else if (add_w < -ilim) integ_nxt = INTEG_W'(-ilim);
    else                    integ_nxt = INTEG_W'(add_w);
  end

  // speed: round half away, clamp to the speed limit, zero once done
  logic             sum_neg;
  logic [SUM_W-1:0] sum_mag, sum_rnd;
  logic [10:0]      spd_mag;
  logic signed [10:0] speed_w;
  logic             done_w;
  logic [ERR_W-1:0] err_mag;

  assign sum_neg = sum_r[SUM_W-1];
  assign sum_mag = sum_neg ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign sum_rnd = (sum_mag + HALF_S) >> FRAC_BITS;
  assign spd_mag = (sum_rnd > SUM_W'(speed_limit_r)) ? 11'(speed_limit_r) : sum_rnd[10:0];
  assign done_w  = (dwell_r >= dwell_ticks_r) || (tick_r >= timeout_ticks_r);
  assign speed_w = done_w ? 11'sd0 : (sum_neg ? -$signed(spd_mag) : $signed(spd_mag));
  assign err_mag = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ERR) err_r <= err_nxt;
    if (cmd.op == OP_MULP || cmd.op == OP_MULI || cmd.op == OP_INTEG) prod_r <= mul_p;
    if (cmd.op == OP_RDES) rdes_r <= rdes_nxt;
    if (cmd.op == OP_SUM) sum_r <= add_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_heading_r <= '0;
      integral_r      <= '0;
      last_good_r     <= '0;
      in_band_r       <= 1'b0;
      dwell_r         <= '0;
      tick_r          <= '0;
    end else if (cmd.capture) begin
      if (in_start_req) begin
        start_heading_r <= in_heading;
        integral_r      <= '0;
        last_good_r     <= '0;
        in_band_r       <= 1'b0;
        dwell_r         <= '0;
        tick_r          <= '0;
      end
    end else begin
      if (cmd.op == OP_RDES && rate_valid_r) last_good_r <= yaw_rate_r;
      if (cmd.op == OP_INTEG) integral_r <= integ_nxt;
      if (cmd.op == OP_SUM) begin
        if (tick_r != 24'hFFFFFF) tick_r <= tick_r + 24'd1;
        if (err_mag <= TOL) begin
          if (!in_band_r) begin
            in_band_r <= 1'b1;
            dwell_r   <= '0;
          end else if (dwell_r != 16'hFFFF) begin
            dwell_r <= dwell_r + 16'd1;
          end
        end else begin
          in_band_r <= 1'b0;
          dwell_r   <= '0;
        end
      end
    end
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_left_speed  <= speed_w;
      out_right_speed <= -speed_w;
      out_done_res    <= done_w;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

// ----- hdl/pivot_turn_heading_controller_core.sv -----
// Top level of the pivot turn heading controller: sequencer plus datapath
//
//   channel  direction  beat contents
//   in_bus   sink       start_req, heading, yaw_rate, rate_valid, rate_limit
//   out_bus  source     left_speed, right_speed, done_res
//   cfg_bus  sink       index, data (always ready)
//
// A tick runs through the accept state and seven steps of the sequencer
// through the one shared multiplier (kp, ki and feed-forward products in turn).
// A stalled out_bus holds the last step until the output register frees up;
// a finished beat waiting there does not block the next tick.
// Reset is synchronous: configuration takes its defaults, loop state clears.
module pivot_turn_heading_controller_core import ptc_pkg::*; #(
  parameter int HEADING_TOLERANCE = PTC_HEADING_TOL_DEF,
  parameter int FRAC_BITS         = PTC_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ptc_in_if.sink      in_bus,
  ptc_out_if.source   out_bus,
  ptc_cfg_if.sink     cfg_bus
);

  ptc_cmd_t cmd;
  ptc_sts_t sts;

  assign cfg_bus.ready = 1'b1;

  ptc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptc_datapath #(
    .HEADING_TOLERANCE (HEADING_TOLERANCE),
    .FRAC_BITS         (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_bus.valid),
    .cfg_index       (cfg_bus.index),
    .cfg_data        (cfg_bus.data),
    .in_start_req    (in_bus.start_req),
    .in_heading      (in_bus.heading),
    .in_yaw_rate     (in_bus.yaw_rate),
    .in_rate_valid   (in_bus.rate_valid),
    .in_rate_limit   (in_bus.rate_limit),
    .out_valid       (out_bus.valid),
    .out_ready       (out_bus.ready),
    .out_left_speed  (out_bus.left_speed),
    .out_right_speed (out_bus.right_speed),
    .out_done_res    (out_bus.done_res)
  );

endmodule

// ----- hdl/ptc_checker.sv -----
// Port-level assertions for the pivot turn controller, bound to the top level
module ptc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [10:0] left_speed,
  input logic signed [10:0] right_speed,
  input logic               done_res
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_speed) &&
    $stable(right_speed) && $stable(done_res))
    else $error("stalled result beat changed");

  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (right_speed == -left_speed) && (left_speed != -11'sd1024))
    else $error("right speed is not the negated left speed");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> left_speed == 11'sd0)
    else $error("nonzero speed on a done beat");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while a tick is at work");

endmodule

bind pivot_turn_heading_controller_core ptc_checker u_ptc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .left_speed  (out_bus.left_speed),
  .right_speed (out_bus.right_speed),
  .done_res    (out_bus.done_res)
);
